[rtl/csc_pkg.sv]
// Shared types and constants for the color space converter.
package csc_pkg;

    localparam int ChanW = 8;
    localparam int ModeW = 3;
    localparam int ProdW = 2 * ChanW;
    localparam int NumLanes = 4;
    localparam logic [ChanW-1:0] ScaleReset = 8'd255;

    typedef enum logic [ModeW-1:0] {
        MODE_RGB2CMY  = 3'd0,
        MODE_CMY2RGB  = 3'd1,
        MODE_CMYK2RGB = 3'd2,
        MODE_CMYK2CMY = 3'd3,
        MODE_RGB2CMYK = 3'd4,
        MODE_CMY2CMYK = 3'd5,
        MODE_RESCALE  = 3'd6,
        MODE_UNUSED   = 3'd7
    } mode_t;

    typedef enum logic {
        REG_FULL_SCALE   = 1'b0,
        REG_TARGET_SCALE = 1'b1
    } reg_addr_t;

    // Per-item sideband that travels down the pipe with each pixel.
    typedef struct packed {
        mode_t            mode;
        logic [ChanW-1:0] full;
        logic [ChanW-1:0] scale;
        logic [ChanW-1:0] base;
        logic [ChanW-1:0] kout;
    } side_t;

endpackage

[rtl/csc_divider.sv]
// Pipelined restoring divider: one quotient bit per stage, with a stall enable.
module csc_divider #(
    parameter int NumW = 16,
    parameter int DenW = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic [NumW-1:0] num,
    input  logic [DenW-1:0] den,
    output logic [NumW-1:0] quo
);
    // Stage s holds the partial remainder after s quotient bits.
    logic [NumW-1:0] rem_reg [NumW+1];
    logic [NumW-1:0] q_reg   [NumW+1];
    logic [DenW-1:0] d_reg   [NumW+1];

    always_comb
    begin
        rem_reg[0] = num;
        q_reg[0]   = '0;
        d_reg[0]   = den;
    end

    for (genvar s = 0; s < NumW; s++)
    begin : g_stage
        localparam int Bit = NumW - 1 - s;
        logic [NumW+DenW-1:0] trial;
        logic                 fits;
        logic [NumW-1:0]      rem_next;
        logic [NumW-1:0]      q_next;
        logic [NumW-1:0]      r_st;
        logic [NumW-1:0]      q_st;
        logic [DenW-1:0]      d_st;

        always_comb
        begin
            trial    = {{DenW{1'b0}}, d_reg[s]} << Bit;
            fits     = (d_reg[s] != '0) && ({{DenW{1'b0}}, rem_reg[s]} >= trial);
            rem_next = fits ? rem_reg[s] - trial[NumW-1:0] : rem_reg[s];
            q_next   = q_reg[s] | (NumW'(fits) << Bit);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                r_st <= '0;
                q_st <= '0;
                d_st <= '0;
            end
            else if (en)
            begin
                r_st <= rem_next;
                q_st <= q_next;
                d_st <= d_reg[s];
            end
        end

        assign rem_reg[s+1] = r_st;
        assign q_reg[s+1]   = q_st;
        assign d_reg[s+1]   = d_st;
    end

    assign quo = q_reg[NumW];

endmodule

[rtl/csc_front.sv]
// Front stages: clamp, per-mode operand selection and multiply, registered.
module csc_front (
    input  logic                        clk,
    input  logic                        en,
    input  logic [csc_pkg::ModeW-1:0]   mode,
    input  logic [csc_pkg::ChanW-1:0]   chan [csc_pkg::NumLanes],
    input  logic [csc_pkg::ChanW-1:0]   full_scale,
    input  logic [csc_pkg::ChanW-1:0]   target_scale,
    output logic [csc_pkg::ProdW-1:0]   num [csc_pkg::NumLanes],
    output logic [csc_pkg::ChanW-1:0]   den,
    output csc_pkg::side_t              side
);
    import csc_pkg::*;

    // stage 1: clamp and reduce
    logic [ChanW-1:0] ch_reg [NumLanes];
    logic [ChanW-1:0] mx_reg, mn_reg;
    side_t            s1_reg;
    logic [ChanW-1:0] tgt_reg;
    logic [ChanW-1:0] ch_next [NumLanes];
    logic [ChanW-1:0] mx_next, mn_next;

    always_comb
    begin
        for (int i = 0; i < NumLanes; i++)
            ch_next[i] = (chan[i] > full_scale) ? full_scale : chan[i];
        mx_next = ch_next[0];
        mn_next = ch_next[0];
        for (int i = 1; i < 3; i++)
        begin
            if (ch_next[i] > mx_next) mx_next = ch_next[i];
            if (ch_next[i] < mn_next) mn_next = ch_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ch_reg  <= ch_next;
            mx_reg  <= mx_next;
            mn_reg  <= mn_next;
            tgt_reg <= target_scale;
            s1_reg  <= '{mode: mode_t'(mode), full: full_scale, scale: full_scale,
                         base: '0, kout: '0};
        end
    end

    // stage 2: multiplier operands
    logic [ChanW-1:0] opa_reg [NumLanes];
    logic [ChanW-1:0] opb_reg;
    logic [ChanW-1:0] den_reg;
    side_t            s2_reg;
    logic [ChanW-1:0] opa_next [NumLanes];
    logic [ChanW-1:0] opb_next, den_next;
    side_t            s2_next;

    always_comb
    begin
        logic [ChanW-1:0] f;
        logic [ChanW-1:0] m;
        f = s1_reg.full;
        m = f - ch_reg[3];
        s2_next  = s1_reg;
        opb_next = '0;
        den_next = f;
        for (int i = 0; i < NumLanes; i++)
            opa_next[i] = '0;
        unique case (s1_reg.mode)
            MODE_RGB2CMY, MODE_CMY2RGB:
            begin
                for (int i = 0; i < 3; i++)
                    opa_next[i] = f - ch_reg[i];
                opb_next = 8'd1;
                den_next = 8'd1;
            end
            MODE_CMYK2RGB, MODE_CMYK2CMY:
            begin
                for (int i = 0; i < 3; i++)
                    opa_next[i] = ch_reg[i];
                opb_next    = m;
                s2_next.base = (s1_reg.mode == MODE_CMYK2RGB) ? m : ch_reg[3];
            end
            MODE_RGB2CMYK:
            begin
                for (int i = 0; i < 3; i++)
                    opa_next[i] = mx_reg - ch_reg[i];
                opb_next     = f;
                den_next     = mx_reg;
                s2_next.kout = f - mx_reg;
            end
            MODE_CMY2CMYK:
            begin
                for (int i = 0; i < 3; i++)
                    opa_next[i] = ch_reg[i] - mn_reg;
                opb_next     = f;
                den_next     = f - mn_reg;
                s2_next.kout = mn_reg;
            end
            MODE_RESCALE:
            begin
                for (int i = 0; i < NumLanes; i++)
                    opa_next[i] = ch_reg[i];
                opb_next      = tgt_reg;
                s2_next.scale = tgt_reg;
            end
            default:
            begin
                den_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            opa_reg <= opa_next;
            opb_reg <= opb_next;
            den_reg <= den_next;
            s2_reg  <= s2_next;
        end
    end

    // stage 3: products
    logic [ProdW-1:0] prod_reg [NumLanes];
    logic [ChanW-1:0] den3_reg;
    side_t            s3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NumLanes; i++)
                prod_reg[i] <= opa_reg[i] * opb_reg;
            den3_reg <= den_reg;
            s3_reg   <= s2_reg;
        end
    end

    assign num  = prod_reg;
    assign den  = den3_reg;
    assign side = s3_reg;

endmodule

[rtl/color_space_converter_unit.sv]
// Pipeline: 3 front stages, 16 divider stages and 1 output stage.
// Throughput: one pixel per clock; the whole pipe advances when the output
// register is empty or taken, so a stall holds every stage in place.
// The divider is a 16-stage restoring divider, one quotient bit per stage.
// Reset: rst_n asynchronous active low clears valid bits; both scale
// registers reset to 255.
module color_space_converter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: mode[2:0], chan_a[10:3], chan_b[18:11], chan_c[26:19], chan_k[34:27]
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: res_a[7:0], res_b[15:8], res_c[23:16], res_k[31:24], res_scale[39:32]
    output logic [39:0] m_axis_tdata
);
    import csc_pkg::*;

    localparam int Depth = 4 + ProdW;

    logic [ChanW-1:0] full_reg, target_reg;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg   <= ScaleReset;
            target_reg <= ScaleReset;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == {REG_FULL_SCALE, 2'b00})
                full_reg <= pwdata[ChanW-1:0];
            else if (paddr == {REG_TARGET_SCALE, 2'b00})
                target_reg <= pwdata[ChanW-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == {REG_FULL_SCALE, 2'b00})
            prdata = {24'd0, full_reg};
        else if (paddr == {REG_TARGET_SCALE, 2'b00})
            prdata = {24'd0, target_reg};
    end

    logic en;
    logic [Depth-1:0] vld_reg;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[Depth-2:0], s_axis_tvalid};
    end

    logic [ChanW-1:0] chan [NumLanes];
    for (genvar i = 0; i < NumLanes; i++)
    begin : g_unpack
        assign chan[i] = s_axis_tdata[ModeW + ChanW*i +: ChanW];
    end

    logic [ProdW-1:0] num [NumLanes];
    logic [ChanW-1:0] den;
    side_t            side;

    csc_front u_front (
        .clk          (clk),
        .en           (en),
        .mode         (s_axis_tdata[ModeW-1:0]),
        .chan         (chan),
        .full_scale   (full_reg),
        .target_scale (target_reg),
        .num          (num),
        .den          (den),
        .side         (side)
    );

    logic [ProdW-1:0] quo [NumLanes];
    for (genvar i = 0; i < NumLanes; i++)
    begin : g_div
        csc_divider #(.NumW(ProdW), .DenW(ChanW)) u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .num   (num[i]),
            .den   (den),
            .quo   (quo[i])
        );
    end

    side_t side_reg [ProdW];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side;
            for (int i = 1; i < ProdW; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // output stage
    logic [39:0] out_reg;
    always_ff @(posedge clk)
    begin
        logic [ChanW-1:0] r [NumLanes];
        side_t s;
        s = side_reg[ProdW-1];
        for (int i = 0; i < NumLanes; i++)
            r[i] = quo[i][ChanW-1:0];
        unique case (s.mode)
            MODE_RGB2CMY, MODE_CMY2RGB:
                r[3] = '0;
            MODE_CMYK2RGB:
            begin
                for (int i = 0; i < 3; i++)
                    r[i] = s.base - quo[i][ChanW-1:0];
                r[3] = '0;
            end
            MODE_CMYK2CMY:
            begin
                for (int i = 0; i < 3; i++)
                    r[i] = s.base + quo[i][ChanW-1:0];
                r[3] = '0;
            end
            MODE_RGB2CMYK, MODE_CMY2CMYK:
                r[3] = s.kout;
            MODE_RESCALE: ;
            default:
                for (int i = 0; i < NumLanes; i++)
                    r[i] = '0;
        endcase
        if (en)
            out_reg <= {s.scale, r[3], r[2], r[1], r[0]};
    end

    assign m_axis_tvalid = vld_reg[Depth-1];
    assign m_axis_tdata  = out_reg;

    property p_stall_holds;
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata) && m_axis_tvalid;
    endproperty
    a_stall_holds: assert property (p_stall_holds) else $error("result changed in stall");

    a_ready_en: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready mismatch");

    a_vld_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |=> $stable(vld_reg))
        else $error("pipe moved while stalled");

endmodule

[sim/tb_color_space_converter_unit.sv]
// Self-checking testbench for the color space converter unit.
`timescale 1ns / 100ps

module tb_color_space_converter_unit;
    import csc_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tdata: mode[2:0], chan_a[10:3], chan_b[18:11], chan_c[26:19], chan_k[34:27]
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tdata: res_a[7:0], res_b[15:8], res_c[23:16], res_k[31:24], res_scale[39:32]
    logic [39:0] m_axis_tdata;

    localparam int WatchdogLimit = 4000;
    localparam int DrainCycles = 40;

    color_space_converter_unit dut (.*);

    always #5 clk = ~clk;

    logic [7:0]  full_reg = 8'd255;
    logic [7:0]  target_reg = 8'd255;
    logic [39:0] pixel_queue[$];
    logic [39:0] expected_pixels[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          quiet_phase = 1'b0;
    bit          hold_sink = 1'b0;
    int          src_gap = 0;
    int          sink_gap = 0;

    function automatic logic [39:0] convert_pixel(logic [39:0] px, logic [7:0] f,
                                                  logic [7:0] t);
        logic [31:0] ch[4];
        logic [31:0] r[4];
        logic [31:0] m;
        logic [31:0] scale;
        mode_t       md;
        md = mode_t'(px[2:0]);
        scale = f;
        for (int i = 0; i < 4; i++)
        begin
            ch[i] = px[3 + 8*i +: 8];
            if (ch[i] > f) ch[i] = f;
            r[i] = 0;
        end
        case (md)
            MODE_RGB2CMY, MODE_CMY2RGB:
                for (int i = 0; i < 3; i++) r[i] = f - ch[i];
            MODE_CMYK2RGB:
            begin
                m = f - ch[3];
                for (int i = 0; i < 3; i++) r[i] = m - (f == 0 ? 0 : m * ch[i] / f);
            end
            MODE_CMYK2CMY:
            begin
                m = f - ch[3];
                for (int i = 0; i < 3; i++) r[i] = ch[3] + (f == 0 ? 0 : m * ch[i] / f);
            end
            MODE_RGB2CMYK:
            begin
                m = ch[0];
                if (ch[1] > m) m = ch[1];
                if (ch[2] > m) m = ch[2];
                r[3] = f - m;
                for (int i = 0; i < 3; i++) r[i] = (m == 0) ? 0 : (m - ch[i]) * f / m;
            end
            MODE_CMY2CMYK:
            begin
                m = ch[0];
                if (ch[1] < m) m = ch[1];
                if (ch[2] < m) m = ch[2];
                r[3] = m;
                for (int i = 0; i < 3; i++)
                    r[i] = (f == m) ? 0 : (ch[i] - m) * f / (f - m);
            end
            MODE_RESCALE:
            begin
                for (int i = 0; i < 4; i++) r[i] = (f == 0) ? 0 : ch[i] * t / f;
                scale = t;
            end
            default: ;
        endcase
        return {scale[7:0], r[3][7:0], r[2][7:0], r[1][7:0], r[0][7:0]};
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        mismatches++;
    endtask

    task automatic write_reg(reg_addr_t idx, logic [7:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(idx) << 2;
        pwdata <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_FULL_SCALE) full_reg = value;
        else target_reg = value;
    endtask

    function automatic logic [39:0] make_pixel(mode_t md, logic [7:0] a, logic [7:0] b,
                                               logic [7:0] c, logic [7:0] k);
        return {5'd0, k, c, b, a, md};
    endfunction

    task automatic wait_drained();
        while (pixel_queue.size() != 0 || expected_pixels.size() != 0 ||
               s_axis_tvalid)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic push_random(int n, bit near_scale);
        logic [7:0] v[4];
        for (int j = 0; j < n; j++)
        begin
            for (int i = 0; i < 4; i++)
                v[i] = (near_scale && $urandom_range(0, 3) == 0) ?
                       full_reg - 8'($urandom_range(0, 2)) : 8'($urandom);
            pixel_queue.push_back({5'd0, v[3], v[2], v[1], v[0], 3'($urandom)});
        end
    endtask

    // Source side: present items from the pending queue with random gaps.
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            expected_pixels.push_back(convert_pixel(s_axis_tdata, full_reg, target_reg));
        if (!(s_axis_tvalid && !s_axis_tready))
        begin
            if (src_gap > 0)
            begin
                src_gap <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pixel_queue.size() != 0)
            begin
                s_axis_tdata <= pixel_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                if (!quiet_phase && $urandom_range(0, 9) == 0)
                    src_gap <= $urandom_range(1, 6);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Sink side: random back-pressure and result checking.
    always @(posedge clk)
    begin
        logic [39:0] want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch("unexpected transfer", m_axis_tdata[7:0], 8'd0);
            else
            begin
                want = expected_pixels.pop_front();
                if (m_axis_tdata[7:0] != want[7:0])
                    report_mismatch("res_a", m_axis_tdata[7:0], want[7:0]);
                if (m_axis_tdata[15:8] != want[15:8])
                    report_mismatch("res_b", m_axis_tdata[15:8], want[15:8]);
                if (m_axis_tdata[23:16] != want[23:16])
                    report_mismatch("res_c", m_axis_tdata[23:16], want[23:16]);
                if (m_axis_tdata[31:24] != want[31:24])
                    report_mismatch("res_k", m_axis_tdata[31:24], want[31:24]);
                if (m_axis_tdata[39:32] != want[39:32])
                    report_mismatch("res_scale", m_axis_tdata[39:32], want[39:32]);
            end
        end
        if (hold_sink)
            m_axis_tready <= 1'b0;
        else if (sink_gap > 0)
        begin
            sink_gap <= sink_gap - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!quiet_phase && $urandom_range(0, 7) == 0)
                sink_gap <= $urandom_range(1, 6);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            hold_sink)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: every mode at reset scales, extremes and corner cases
        for (int md = 0; md < 8; md++)
        begin
            pixel_queue.push_back(make_pixel(mode_t'(md), 8'd255, 8'd0, 8'd128, 8'd255));
            pixel_queue.push_back(make_pixel(mode_t'(md), 8'd0, 8'd0, 8'd0, 8'd0));
        end
        pixel_queue.push_back(make_pixel(MODE_RGB2CMYK, 8'd0, 8'd0, 8'd0, 8'd9));
        pixel_queue.push_back(make_pixel(MODE_CMY2CMYK, 8'd255, 8'd255, 8'd255, 8'd0));
        pixel_queue.push_back(make_pixel(MODE_CMYK2RGB, 8'd200, 8'd17, 8'd99, 8'd64));
        wait_drained();

        write_reg(REG_FULL_SCALE, 8'd100);
        write_reg(REG_TARGET_SCALE, 8'd1);
        pixel_queue.push_back(make_pixel(MODE_RESCALE, 8'd255, 8'd100, 8'd50, 8'd99));
        pixel_queue.push_back(make_pixel(MODE_CMY2CMYK, 8'd200, 8'd100, 8'd150, 8'd0));
        pixel_queue.push_back(make_pixel(MODE_RGB2CMYK, 8'd101, 8'd3, 8'd0, 8'd0));
        push_random(200, 1'b1);
        wait_drained();

        // long sink hold while the source keeps offering
        write_reg(REG_FULL_SCALE, 8'd255);
        write_reg(REG_TARGET_SCALE, 8'd255);
        push_random(150, 1'b0);
        hold_sink = 1'b1;
        repeat (120) @(posedge clk);
        hold_sink = 1'b0;
        wait_drained();

        write_reg(REG_FULL_SCALE, 8'd1);
        write_reg(REG_TARGET_SCALE, 8'd200);
        push_random(200, 1'b1);
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            write_reg(REG_FULL_SCALE, 8'($urandom_range(1, 255)));
            write_reg(REG_TARGET_SCALE, 8'($urandom_range(1, 255)));
            push_random(200, 1'b1);
            wait_drained();
        end

        write_reg(REG_FULL_SCALE, 8'd255);
        write_reg(REG_TARGET_SCALE, 8'd37);
        quiet_phase = 1'b1;
        push_random(200, 1'b0);
        wait_drained();

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
